[hw/rtl/sstf_pkg.sv]
package sstf_pkg;

    // Fixed field widths of the request and result transfers.
    localparam int CYL_W   = 16;
    localparam int TOTAL_W = 21;
    // The running sum is kept one bit wider so that saturation can be seen.
    localparam int SUM_W   = 22;

    localparam logic [SUM_W-1:0] TOTAL_MAX = SUM_W'(2097151);

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_START_CYLINDER = 1'b0;

endpackage

[hw/rtl/sstf_ifs.sv]
interface sstf_req_if;
    import sstf_pkg::*;

    logic             valid;
    logic             ready;
    logic [CYL_W-1:0] cylinder;
    logic             batch_end;

    modport source (output valid, output cylinder, output batch_end, input ready);
    modport sink   (input valid, input cylinder, input batch_end, output ready);
endinterface

interface sstf_res_if;
    import sstf_pkg::*;

    logic               valid;
    logic               ready;
    logic [CYL_W-1:0]   served_cylinder;
    logic [CYL_W-1:0]   seek_distance;
    logic [TOTAL_W-1:0] total_seek;
    logic               overflowed;
    logic               final_result;

    modport source (output valid, output served_cylinder, output seek_distance,
                    output total_seek, output overflowed, output final_result,
                    input ready);
    modport sink   (input valid, input served_cylinder, input seek_distance,
                    input total_seek, input overflowed, input final_result,
                    output ready);
endinterface

[hw/rtl/sstf_cell.sv]
module sstf_cell #(
    parameter int  IDX_W  = 5,
    parameter int  INDEX  = 0,
    parameter type t_best = logic,
    parameter type t_ctl  = logic
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctl                      i_ctl,
    input  logic [sstf_pkg::CYL_W-1:0] i_head,
    input  t_best                     i_best,
    output t_best                     o_best
);
    import sstf_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [CYL_W-1:0] r_cyl;
    logic             r_pend;
    t_best            r_best;
    t_best            n_best;
    logic [CYL_W-1:0] w_dist;

    assign w_dist = (r_cyl > i_head) ? (r_cyl - i_head) : (i_head - r_cyl);

    // Strictly smaller wins, so the earlier entry keeps a tie.
    always_comb begin
        n_best = i_best;
        if (r_pend && (!i_best.found || (w_dist < i_best.seek))) begin
            n_best.found = 1'b1;
            n_best.seek  = w_dist;
            n_best.cyl   = r_cyl;
            n_best.idx   = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_ctl.load_idx == MY_IDX)) begin
            r_cyl <= i_ctl.cyl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend       <= 1'b0;
            r_best.found <= 1'b0;
        end else begin
            if (i_ctl.load && (i_ctl.load_idx == MY_IDX)) begin
                r_pend <= 1'b1;
            end else if (i_ctl.serve && (i_ctl.serve_idx == MY_IDX)) begin
                r_pend <= 1'b0;
            end
            r_best.found <= n_best.found;
        end
        r_best.seek <= n_best.seek;
        r_best.cyl  <= n_best.cyl;
        r_best.idx  <= n_best.idx;
    end

    assign o_best = r_best;

endmodule

[hw/rtl/shortest_seek_first_scheduler_core.sv]
// Shortest-seek-first disk scheduler.
//
// Requests arrive as transfers on i_req (cylinder, batch_end). Each transfer
// is accepted while loading and written into the next free cell of a row of
// TABLE_DEPTH cells; requests beyond the row are dropped and the batch is
// marked as overflowed. The transfer with batch_end set is loaded like the
// others and then starts service from the start cylinder held in the APB
// register at address 0.
//
// Each service step is a sweep down the cell row: every cell compares its
// own distance to the head with the best candidate handed on by its left
// neighbour, one cell per cycle, and registers the better of the two.
// A batch yields one result per stored request, so at most TABLE_DEPTH.
// i_req is not ready while a batch is being served.
//
// Results leave through an output register on o_res; the next sweep runs
// while a result waits, and a stalled receiver only holds back the capture
// of the following result. Reset empties the row and the output register
// and clears the start cylinder to zero; no clearing pass is needed.
module shortest_seek_first_scheduler_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sstf_req_if.sink                     i_req,
    sstf_res_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sstf_pkg::APB_AW-1:0]  paddr,
    input  logic [sstf_pkg::APB_DW-1:0]  pwdata,
    output logic [sstf_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import sstf_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef struct packed {
        logic             found;
        logic [CYL_W-1:0] seek;
        logic [CYL_W-1:0] cyl;
        logic [IDX_W-1:0] idx;
    } t_best;

    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] load_idx;
        logic [CYL_W-1:0] cyl;
        logic             serve;
        logic [IDX_W-1:0] serve_idx;
    } t_ctl;

    typedef enum logic [1:0] {
        S_LOAD   = 2'b01,
        S_SEARCH = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [CYL_W-1:0] r_start;
    logic [CYL_W-1:0] r_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_remaining;
    logic [CNT_W-1:0] r_wait;
    logic             r_drop, n_drop;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;

    logic               r_out_valid;
    logic [CYL_W-1:0]   r_served;
    logic [CYL_W-1:0]   r_dist;
    logic [TOTAL_W-1:0] r_total;
    logic               r_ovf;
    logic               r_final;

    logic  w_cfg_wr;
    logic  w_accept;
    logic  w_capture;
    logic  w_last_step;
    t_ctl  w_ctl;
    t_best w_chain [TABLE_DEPTH+1];

    // Configuration port: writes complete in the access phase.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_START_CYLINDER);
    assign prdata   = (paddr[2] == REG_START_CYLINDER) ? APB_DW'(r_start) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (w_cfg_wr) begin
            r_start <= pwdata[CYL_W-1:0];
        end
    end

    // Loading side.
    assign i_req.ready = (r_state == S_LOAD);
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        n_count = r_count;
        n_drop  = r_drop;
        if (w_accept) begin
            if (r_count < CNT_FULL) begin
                n_count = r_count + CNT_ONE;
            end else begin
                n_drop = 1'b1;
            end
        end
    end

    // The last cell holds the winner once a sweep has run the whole row.
    assign w_capture   = (r_state == S_SEARCH) && (r_wait == CNT_FULL) &&
                         (!r_out_valid || o_res.ready);
    assign w_last_step = (r_remaining == CNT_ONE);

    assign n_sum = r_sum + SUM_W'(w_chain[TABLE_DEPTH].seek);

    always_comb begin
        w_ctl.load      = w_accept && (r_count < CNT_FULL);
        w_ctl.load_idx  = r_count[IDX_W-1:0];
        w_ctl.cyl       = i_req.cylinder;
        w_ctl.serve     = w_capture;
        w_ctl.serve_idx = w_chain[TABLE_DEPTH].idx;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_accept && i_req.batch_end) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_capture && w_last_step) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_remaining <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LOAD) begin
                r_count <= n_count;
                r_drop  <= n_drop;
                if (w_accept && i_req.batch_end) begin
                    r_remaining <= n_count;
                    r_wait      <= '0;
                end
            end else begin
                if (w_capture) begin
                    r_remaining <= r_remaining - CNT_ONE;
                    r_wait      <= '0;
                    if (w_last_step) begin
                        r_count <= '0;
                        r_drop  <= 1'b0;
                    end
                end else if (r_wait != CNT_FULL) begin
                    r_wait <= r_wait + CNT_ONE;
                end
            end
            if (w_capture) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Head, running sum and result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_req.batch_end) begin
            r_head <= r_start;
            r_sum  <= '0;
        end else if (w_capture) begin
            r_head <= w_chain[TABLE_DEPTH].cyl;
            r_sum  <= n_sum;
        end
        if (w_capture) begin
            r_served <= w_chain[TABLE_DEPTH].cyl;
            r_dist   <= w_chain[TABLE_DEPTH].seek;
            r_total  <= (n_sum > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0] : n_sum[TOTAL_W-1:0];
            r_ovf    <= r_drop;
            r_final  <= w_last_step;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.served_cylinder = r_served;
    assign o_res.seek_distance   = r_dist;
    assign o_res.total_seek      = r_total;
    assign o_res.overflowed      = r_ovf;
    assign o_res.final_result    = r_final;

    // The row of cells; the chain enters with no candidate.
    assign w_chain[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        sstf_cell #(
            .IDX_W  (IDX_W),
            .INDEX  (g),
            .t_best (t_best),
            .t_ctl  (t_ctl)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_ctl),
            .i_head (r_head),
            .i_best (w_chain[g]),
            .o_best (w_chain[g+1])
        );
    end

    // A batch in service always has work left.
    a_remaining_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_remaining != '0))
        else $error("batch in service with nothing left to serve");

    // The fill count never passes the row length.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("fill count beyond table depth");

    // A completed sweep always finds a pending request.
    a_capture_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_capture |-> w_chain[TABLE_DEPTH].found)
        else $error("sweep ended without a candidate");

    // After the final result the row is empty and loading resumes.
    a_final_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_capture && w_last_step) |=> ((r_state == S_LOAD) && (r_count == '0)))
        else $error("batch did not close after its final result");

    // A waiting result is never overwritten.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !w_capture)
        else $error("result captured over a stalled one");

endmodule
